// File: hdl/togu_pkg.sv
// Shared types and codes for the timestamp-ordered resource grant unit.
package togu_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_INS_HEAD,
        ST_REL_FIND,
        ST_REL_SHIFT,
        ST_SCAN_START,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_REL_EMPTY = 2'd1,
        STAT_INS_FULL  = 2'd2
    } t_status;

    localparam logic        ACT_INSERT  = 1'b0;
    localparam logic        ACT_RELEASE = 1'b1;
    localparam logic [9:0]  CAP_RESET   = 10'd20;
    localparam logic        REG_CAP     = 1'b0;

endpackage

// File: hdl/timestamp_ordered_resource_grant_unit.sv
// Top level: sorted request table in one memory, admission scan, grant output stage.
// Usage
//   Input stream (s_*): one beat is a request insert (s_tuser = 0) or a release
//   (s_tuser = 1) carrying stamp, requester id and amount. The table stays sorted
//   by (stamp, requester); a release drops the first entry of that requester.
//   After each beat the unit walks from the head, summing amounts while they fit
//   in the capacity register, and sends one output beat per newly granted
//   requester (m_tuser = 1, m_tlast on the final one). With no new grant, or on
//   a release into an empty table or an insert into a full one, a single beat
//   with m_tuser = 0, the status code and m_tlast = 1 is sent.
//   User writes capacity over the APB port at byte address 0 while idle (unchecked).
// Timing
//   One synchronous memory holds all entries (one read, one write per cycle).
//   A beat is accepted, then an insert walks down from the tail or a release
//   walks up from the head, then the scan sets up and walks entry by entry,
//   then the final beat is sent. The longest beat is an insert at the head of
//   a nearly full table. s_tready is high only in idle.
// Reset and stall
//   Reset empties the table (count to zero) and loads capacity 20. A stalled
//   receiver holds the output register; the scan pauses until a beat is taken.
module timestamp_ordered_resource_grant_unit
    import togu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] stamp, [39:32] requester, [43:40] amount
    input  logic        s_tuser,   // [0] action
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] grant_id, [9:8] status
    output logic        m_tuser,   // [0] granted
    output logic        m_tlast
);

    localparam int AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int IDW = ID_BITS;
    localparam int EW  = 37 + IDW;   // {stamp, id, amount, granted}

    // control and payload registers
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_idx, n_idx;
    logic            r_act, n_act;
    logic [31:0]     r_stamp, n_stamp;
    logic [IDW-1:0]  r_id, n_id;
    logic [3:0]      r_amt, n_amt;
    logic [9:0]      r_sum, n_sum;
    logic            r_pend_v, n_pend_v;
    logic [IDW-1:0]  r_pend_id, n_pend_id;
    t_status         r_status, n_status;
    logic [9:0]      r_cap;
    logic            r_m_valid, n_m_valid;
    logic            r_m_gnt, n_m_gnt;
    logic [7:0]      r_m_id, n_m_id;
    t_status         r_m_status, n_m_status;
    logic            r_m_last, n_m_last;

    // entry memory
    logic [EW-1:0]   mem [QUEUE_DEPTH];
    logic [EW-1:0]   r_rdata;
    logic            mem_re, mem_we;
    logic [AW-1:0]   mem_raddr, mem_waddr;
    logic [EW-1:0]   mem_wdata;

    logic [31:0]     rd_stamp;
    logic [IDW-1:0]  rd_id;
    logic [3:0]      rd_amt;
    logic            rd_gnt;
    logic            new_less, at_last, fits, out_free, s_acc, cfg_wr;
    logic [10:0]     sum_next;
    logic [EW-1:0]   new_entry;

    assign rd_gnt    = r_rdata[0];
    assign rd_amt    = r_rdata[4:1];
    assign rd_id     = r_rdata[5 +: IDW];
    assign rd_stamp  = r_rdata[5 + IDW +: 32];
    assign new_entry = {r_stamp, r_id, r_amt, 1'b0};

    assign new_less = (r_stamp < rd_stamp) || ((r_stamp == rd_stamp) && (r_id < rd_id));
    assign at_last  = ((CW'(r_idx) + CW'(1)) == r_count);
    assign sum_next = {1'b0, r_sum} + 11'(rd_amt);
    assign fits     = (sum_next <= {1'b0, r_cap});
    assign out_free = !r_m_valid || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_CAP) ? {22'd0, r_cap} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (cfg_wr && (paddr[2] == REG_CAP)) begin
            r_cap <= pwdata[9:0];
        end
    end

    // stream ports
    assign s_tready = (r_state == ST_IDLE);
    assign m_tvalid = r_m_valid;
    assign m_tdata  = {6'd0, r_m_status, r_m_id};
    assign m_tuser  = r_m_gnt;
    assign m_tlast  = r_m_last;

    // memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_pend_v  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pend_v  <= n_pend_v;
            r_m_valid <= n_m_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_act      <= n_act;
        r_stamp    <= n_stamp;
        r_id       <= n_id;
        r_amt      <= n_amt;
        r_sum      <= n_sum;
        r_pend_id  <= n_pend_id;
        r_status   <= n_status;
        r_m_gnt    <= n_m_gnt;
        r_m_id     <= n_m_id;
        r_m_status <= n_m_status;
        r_m_last   <= n_m_last;
    end

    // sequencer: insert walks down from the tail, release walks up from the
    // head, then the admission scan walks up from the head
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_act      = r_act;
        n_stamp    = r_stamp;
        n_id       = r_id;
        n_amt      = r_amt;
        n_sum      = r_sum;
        n_pend_v   = r_pend_v;
        n_pend_id  = r_pend_id;
        n_status   = r_status;
        n_m_valid  = r_m_valid && !m_tready;
        n_m_gnt    = r_m_gnt;
        n_m_id     = r_m_id;
        n_m_status = r_m_status;
        n_m_last   = r_m_last;
        mem_re     = 1'b0;
        mem_raddr  = r_idx;
        mem_we     = 1'b0;
        mem_waddr  = r_idx;
        mem_wdata  = r_rdata;

        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_act    = s_tuser;
                    n_stamp  = s_tdata[31:0];
                    n_id     = IDW'(s_tdata[39:32]);
                    n_amt    = s_tdata[43:40];
                    n_pend_v = 1'b0;
                    n_status = STAT_OK;
                    if (s_tuser == ACT_INSERT) begin
                        if (r_count == CW'(QUEUE_DEPTH)) begin
                            n_status = STAT_INS_FULL;
                            n_state  = ST_FLUSH;
                        end else if (r_count == '0) begin
                            n_idx   = '0;
                            n_state = ST_INS_HEAD;
                        end else begin
                            // fetch the tail entry
                            mem_re    = 1'b1;
                            mem_raddr = AW'(r_count - CW'(1));
                            n_idx     = mem_raddr;
                            n_state   = ST_INS;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = STAT_REL_EMPTY;
                            n_state  = ST_FLUSH;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = '0;
                            n_idx     = '0;
                            n_state   = ST_REL_FIND;
                        end
                    end
                end
            end

            ST_INS: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_idx + AW'(1));
                if (new_less) begin
                    // move the entry up one place, keep walking down
                    mem_wdata = r_rdata;
                    if (r_idx == '0) begin
                        n_state = ST_INS_HEAD;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(r_idx - AW'(1));
                        n_idx     = mem_raddr;
                    end
                end else begin
                    mem_wdata = new_entry;
                    n_count   = CW'(r_count + CW'(1));
                    n_state   = ST_SCAN_START;
                end
            end

            ST_INS_HEAD: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = new_entry;
                n_count   = CW'(r_count + CW'(1));
                n_state   = ST_SCAN_START;
            end

            ST_REL_FIND: begin
                if (rd_id == r_id) begin
                    if (at_last) begin
                        n_count = CW'(r_count - CW'(1));
                        n_state = ST_SCAN_START;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(r_idx + AW'(1));
                        n_idx     = mem_raddr;
                        n_state   = ST_REL_SHIFT;
                    end
                end else if (at_last) begin
                    // no match: table unchanged
                    n_state = ST_SCAN_START;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(r_idx + AW'(1));
                    n_idx     = mem_raddr;
                end
            end

            ST_REL_SHIFT: begin
                // close the gap: move entry down one place
                mem_we    = 1'b1;
                mem_waddr = AW'(r_idx - AW'(1));
                mem_wdata = r_rdata;
                if (at_last) begin
                    n_count = CW'(r_count - CW'(1));
                    n_state = ST_SCAN_START;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(r_idx + AW'(1));
                    n_idx     = mem_raddr;
                end
            end

            ST_SCAN_START: begin
                n_sum    = '0;
                n_pend_v = 1'b0;
                n_status = STAT_OK;
                if (r_count == '0) begin
                    n_state = ST_FLUSH;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = '0;
                    n_idx     = '0;
                    n_state   = ST_SCAN;
                end
            end

            ST_SCAN: begin
                if (!fits) begin
                    n_state = ST_FLUSH;
                end else if (!rd_gnt && r_pend_v && !out_free) begin
                    // hold: the pending grant cannot move to the output yet
                    n_state = ST_SCAN;
                end else begin
                    n_sum = sum_next[9:0];
                    if (!rd_gnt) begin
                        if (r_pend_v) begin
                            n_m_valid  = 1'b1;
                            n_m_gnt    = 1'b1;
                            n_m_id     = 8'(r_pend_id);
                            n_m_status = STAT_OK;
                            n_m_last   = 1'b0;
                        end
                        n_pend_v  = 1'b1;
                        n_pend_id = rd_id;
                        mem_we    = 1'b1;
                        mem_waddr = r_idx;
                        mem_wdata = {r_rdata[EW-1:1], 1'b1};
                    end
                    if (at_last) begin
                        n_state = ST_FLUSH;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(r_idx + AW'(1));
                        n_idx     = mem_raddr;
                    end
                end
            end

            ST_FLUSH: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_last  = 1'b1;
                    if (r_pend_v) begin
                        n_m_gnt    = 1'b1;
                        n_m_id     = 8'(r_pend_id);
                        n_m_status = STAT_OK;
                    end else begin
                        n_m_gnt    = 1'b0;
                        n_m_id     = '0;
                        n_m_status = r_status;
                    end
                    n_pend_v = 1'b0;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count above table depth");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !mem_we)
        else $error("table written while idle");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state != ST_IDLE))
        else $error("accepted beat did not start work");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count)) ||
                           (r_count == CW'($past(r_count) + CW'(1))) ||
                           (r_count == CW'($past(r_count) - CW'(1))))
        else $error("entry count moved by more than one");

    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_gnt) |-> (r_m_status == STAT_OK))
        else $error("grant beat carries an error status");

    a_mid_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !r_m_last) |-> r_m_gnt)
        else $error("non-final beat without a grant");

endmodule

// File: verif/tb.sv
// Self-checking bench for the timestamp-ordered resource grant unit.
`timescale 1ns / 1ps

module tb
    import togu_pkg::*;
();

    localparam int          DEPTH        = 16;
    localparam int          IDLE_SETTLE  = 48;      // worst case per beat, plus margin
    localparam int          GAP_MAX      = 40;
    localparam int          HOLD_CYCLES  = 300;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam logic [2:0]  ADDR_CAP     = {REG_CAP, 2'b00};
    localparam logic [2:0]  ADDR_SPARE   = 3'd4;    // first index past the register list

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_PATTERN
    } t_rx_mode;

    // one pending request as the table holds it
    typedef struct packed {
        logic [31:0] stamp;
        logic [7:0]  req;
        logic [3:0]  amt;
        logic        granted;
    } t_slot;

    // one result beat as it should leave the block
    typedef struct packed {
        logic    granted;
        logic [7:0] id;
        t_status status;
        logic    last;
    } t_grant_beat;

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;     // [31:0] stamp, [39:32] requester, [43:40] amount
    logic        s_tuser  = 1'b0;   // [0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [7:0] grant_id, [9:8] status
    logic        m_tuser;           // [0] granted
    logic        m_tlast;

    // shadow of the grant table and the capacity register
    t_slot       tbl [DEPTH];
    int unsigned held          = 0;
    logic [9:0]  cap_model     = CAP_RESET;
    t_grant_beat pending_grants[$];

    logic [31:0] stamp_clock;
    int          burst_left    = 0;
    int          gap_max       = GAP_MAX;
    int          mismatch_count = 0;
    int unsigned cycle_count   = 0;

    // receiver state
    logic        hold_pending  = 1'b0;
    int          hold_left     = 0;
    t_rx_mode    rx_mode       = RX_OPEN;

    timestamp_ordered_resource_grant_unit #(
        .QUEUE_DEPTH (DEPTH),
        .ID_BITS     (8)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Hard stop: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Apply one accepted request to the shadow table and queue the beats it
    // should produce: sorted insert or first-match removal, then the
    // admission walk from the head.
    function automatic void admit_and_grant(input logic act, input logic [31:0] stamp,
                                            input logic [7:0] req, input logic [3:0] amt);
        int unsigned pos;
        int unsigned k;
        int unsigned total;
        bit          any_grant;
        if (act == ACT_INSERT && held == DEPTH) begin
            pending_grants.push_back('{granted: 1'b0, id: 8'd0, status: STAT_INS_FULL,
                                       last: 1'b1});
            return;
        end
        if (act == ACT_RELEASE && held == 0) begin
            pending_grants.push_back('{granted: 1'b0, id: 8'd0, status: STAT_REL_EMPTY,
                                       last: 1'b1});
            return;
        end
        if (act == ACT_INSERT) begin
            // land after every entry whose key is less than or equal
            pos = held;
            for (k = 0; k < held; k++) begin
                if (stamp < tbl[k].stamp || (stamp == tbl[k].stamp && req < tbl[k].req)) begin
                    pos = k;
                    break;
                end
            end
            for (k = held; k > pos; k--)
                tbl[k] = tbl[k - 1];
            tbl[pos] = '{stamp: stamp, req: req, amt: amt, granted: 1'b0};
            held++;
        end else begin
            // drop the first entry of this requester; a miss leaves the table as is
            for (k = 0; k < held; k++) begin
                if (tbl[k].req == req) begin
                    for (int unsigned j = k; j + 1 < held; j++)
                        tbl[j] = tbl[j + 1];
                    held--;
                    break;
                end
            end
        end
        total     = 0;
        any_grant = 1'b0;
        for (k = 0; k < held; k++) begin
            if (total + tbl[k].amt > cap_model)
                break;
            total += tbl[k].amt;
            if (!tbl[k].granted) begin
                tbl[k].granted = 1'b1;
                pending_grants.push_back('{granted: 1'b1, id: tbl[k].req, status: STAT_OK,
                                           last: 1'b0});
                any_grant = 1'b1;
            end
        end
        if (!any_grant)
            pending_grants.push_back('{granted: 1'b0, id: 8'd0, status: STAT_OK, last: 1'b1});
        else
            pending_grants[pending_grants.size() - 1].last = 1'b1;
    endfunction

    // Logical-clock stamps: mostly creeping forward with ties, now and then
    // late arrivals and stamps from anywhere in the 32-bit range.
    function automatic logic [31:0] next_stamp();
        int sel;
        sel = $urandom_range(19);
        if (sel == 0)
            return $urandom;
        if (sel == 1)
            return stamp_clock - 32'($urandom_range(6));
        stamp_clock = stamp_clock + 32'($urandom_range(2));
        return stamp_clock;
    endfunction

    // Offer one beat, hold it until taken, then record it in the shadow model.
    // Between bursts drop valid for a random gap, unless the gap limit is zero.
    task automatic offer_request(input logic act, input logic [31:0] stamp,
                                 input logic [7:0] req, input logic [3:0] amt);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'b0000, amt, req, stamp};
        do @(posedge i_clk); while (!s_tready);
        admit_and_grant(act, stamp, req, amt);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(12);
            if (gap_max != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(gap_max, 1)) @(posedge i_clk);
            end
        end
    endtask

    // Drain every expected beat, then let a full worst-case item time pass
    // so nothing is still in flight inside the block.
    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    // Write a register while idle, then read capacity back.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        wait_for_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_CAP)
            cap_model = data[9:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_CAP;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[9:0] !== cap_model)
            note_mismatch("capacity readback", prdata, 32'(cap_model));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly well-formed traffic: inserts from a small requester pool and
    // releases of ids that hold an entry (often the head), plus empty-table
    // releases, full-table inserts and releases that match nothing.
    task automatic run_traffic(input int count);
        int          pick;
        logic        act;
        logic [7:0]  req;
        logic [3:0]  amt;
        logic [31:0] stamp;
        repeat (count) begin
            pick  = $urandom_range(99);
            stamp = next_stamp();
            req   = ($urandom_range(6) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
            amt   = ($urandom_range(4) == 0) ? 4'd0 : 4'($urandom_range(15));
            if (held == 0)
                act = (pick < 8) ? ACT_RELEASE : ACT_INSERT;
            else if (held == DEPTH)
                act = (pick < 25) ? ACT_INSERT : ACT_RELEASE;
            else
                act = (pick < 52) ? ACT_INSERT : ACT_RELEASE;
            if (act == ACT_RELEASE && held != 0 && pick % 10 != 0)
                req = (pick % 3 == 0) ? tbl[0].req : tbl[$urandom_range(held - 1)].req;
            offer_request(act, stamp, req, amt);
        end
    endtask

    // Receiver: on a hold request go dark for a long stretch; otherwise
    // switch between stall patterns, picked at random.
    always @(posedge i_clk) begin
        if (hold_pending) begin
            hold_pending <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            if (cycle_count % 50 == 0)
                rx_mode <= t_rx_mode'($urandom_range(3));
            case (rx_mode)
                RX_OPEN:  m_tready <= 1'b1;
                RX_LIGHT: m_tready <= ($urandom_range(3) != 0);
                RX_HEAVY: m_tready <= 1'($urandom_range(1));
                default:  m_tready <= (cycle_count[2:0] < 3'd3);
            endcase
        end
    end

    // Compare every taken result beat with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_grant_beat want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_grants.size() == 0) begin
                note_mismatch("beat with nothing pending", 32'(m_tdata), 32'd0);
            end else begin
                want = pending_grants.pop_front();
                if (m_tuser !== want.granted)
                    note_mismatch("granted", 32'(m_tuser), 32'(want.granted));
                if (m_tdata[7:0] !== want.id)
                    note_mismatch("grant_id", 32'(m_tdata[7:0]), 32'(want.id));
                if (m_tdata[9:8] !== want.status)
                    note_mismatch("status", 32'(m_tdata[9:8]), 32'(want.status));
                if (m_tlast !== want.last)
                    note_mismatch("last", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    // Field extremes, both operations, ties, a miss, a full table.
    task automatic test_directed_cases();
        offer_request(ACT_RELEASE, 32'd0, 8'd5, 4'd0);             // release on empty table
        offer_request(ACT_INSERT, 32'd0, 8'd0, 4'd0);              // all-zero request
        offer_request(ACT_INSERT, 32'hFFFF_FFFF, 8'd255, 4'd15);   // all-ones request
        offer_request(ACT_INSERT, 32'd100, 8'd7, 4'd3);
        offer_request(ACT_INSERT, 32'd100, 8'd7, 4'd9);            // equal key goes behind
        offer_request(ACT_INSERT, 32'd100, 8'd6, 4'd15);           // lower id wins the tie
        offer_request(ACT_RELEASE, 32'd0, 8'd200, 4'd0);           // no match, walk still runs
        offer_request(ACT_RELEASE, 32'hFFFF_FFFF, 8'd7, 4'd15);    // first of two matches
        offer_request(ACT_INSERT, 32'h8000_0000, 8'h80, 4'd8);
        while (held < DEPTH)
            offer_request(ACT_INSERT, next_stamp(), 8'($urandom_range(255)),
                          4'($urandom_range(15)));
        offer_request(ACT_INSERT, 32'd1, 8'd1, 4'd1);              // insert into full table
        offer_request(ACT_RELEASE, 32'd0, 8'd255, 4'd0);
        offer_request(ACT_RELEASE, 32'd0, 8'd0, 4'd0);
    endtask

    // Capacity at both ends and in between; junk in the upper write bits,
    // plus a write to an index past the register list.
    task automatic test_capacity_sweep();
        apb_write(ADDR_CAP, {22'($urandom), 10'd0});
        run_traffic(70);
        apb_write(ADDR_CAP, {22'($urandom), 10'd1023});
        run_traffic(70);
        apb_write(ADDR_SPARE, $urandom);
        run_traffic(70);
        apb_write(ADDR_CAP, {22'($urandom), 10'($urandom_range(12, 1))});
        run_traffic(70);
        apb_write(ADDR_CAP, {22'($urandom), 10'($urandom_range(90, 25))});
        run_traffic(70);
    endtask

    // Stall the result side for a long stretch while the sender keeps
    // offering back-to-back beats, so the block must stall its input.
    task automatic test_output_backpressure();
        apb_write(ADDR_CAP, {22'($urandom), 10'd60});
        gap_max = 0;
        hold_pending <= 1'b1;
        run_traffic(40);
        gap_max = GAP_MAX;
    endtask

    task automatic test_random_traffic();
        apb_write(ADDR_CAP, {22'($urandom), CAP_RESET});
        run_traffic(50);
    endtask

    initial begin
        stamp_clock = $urandom;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_capacity_sweep();
        test_output_backpressure();
        test_random_traffic();
        wait_for_idle();
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
hdl/togu_pkg.sv
hdl/timestamp_ordered_resource_grant_unit.sv
verif/tb.sv
